### rtl/nvbs_pkg.sv
// nvbs_pkg: shared widths and types of the nearest value binary search unit
// used by the channel interfaces, the table memory and the search controller
`default_nettype none

package nvbs_pkg;

  // fixed field widths
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 6;

  // table memory access from the controller
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_idx;
  } mem_req_t;

  // controller status toward the top level
  typedef struct packed {
    logic busy;
    logic probing;
  } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/nvbs_if.sv
// nvbs_if: valid/ready channel interfaces for request and response items
// depends on nvbs_pkg for the field widths
`default_nettype none

interface nvbs_req_if
  import nvbs_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output req_type, output entry_index, output data_value,
                  input ready);
  modport sink   (input valid, input req_type, input entry_index, input data_value,
                  output ready);
endinterface

interface nvbs_rsp_if
  import nvbs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] nearest_index;

  modport source (output valid, output nearest_index, input ready);
  modport sink   (input valid, input nearest_index, output ready);
endinterface

`default_nettype wire

### rtl/nvbs_table.sv
// nvbs_table: value table, one write port and one registered read port
// depends on nvbs_pkg for the access struct
`default_nettype none

module nvbs_table
  import nvbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire mem_req_t          mem_req_i,
  output logic [DATA_W-1:0]      rd_data_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [DATA_W-1:0]   mem_q [TABLE_DEPTH];
  logic [AW+IDX_W-1:0] wr_ext;
  logic [AW+IDX_W-1:0] rd_ext;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                wr_in_range;

  // fit the slot index to the memory address width
  assign wr_ext      = {{AW{1'b0}}, mem_req_i.wr_idx};
  assign rd_ext      = {{AW{1'b0}}, mem_req_i.rd_idx};
  assign wr_addr     = wr_ext[AW-1:0];
  assign rd_addr     = rd_ext[AW-1:0];
  assign wr_in_range = (32'(mem_req_i.wr_idx) < TABLE_DEPTH);

  // writes beyond the depth are dropped
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en && wr_in_range) begin
      mem_q[wr_addr] <= mem_req_i.wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/nvbs_ctrl.sv
// nvbs_ctrl: entry count register, bisection sequencer and result register
// depends on nvbs_pkg and the channel interfaces in nvbs_if
`default_nettype none

module nvbs_ctrl
  import nvbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  nvbs_req_if.sink          req_i,
  nvbs_rsp_if.source        rsp_o,
  input  wire logic [DATA_W-1:0] rd_data_i,
  output mem_req_t          mem_req_o,
  output ctrl_status_t      status_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IDX_W-1:0]         res_q, res_d;
  logic signed [DATA_W-1:0] query_q, query_d;
  logic signed [DATA_W-1:0] probe_q, probe_d;
  logic                     out_valid_q, out_valid_d;
  logic [IDX_W-1:0]         out_idx_q, out_idx_d;

  logic [CNT_W-1:0]         n_sat;
  logic [CNT_W-1:0]         n_m1;
  logic [IDX_W-1:0]         span;
  logic [IDX_W-1:0]         span_n;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W:0]   diff_lo;
  logic signed [DATA_W:0]   diff_hi;
  logic                     pick_hi;
  logic                     in_xfer;
  logic                     out_load;

  // entry count, saturated to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign n_sat   = (32'(count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_q;
  assign n_m1    = n_sat - CNT_W'(1);
  assign rd_val  = $signed(rd_data_i);
  assign span    = hi_q - lo_q;

  // nearest-of-two choice at 33 bits, ties to the higher index
  assign diff_lo = {query_q[DATA_W-1], query_q} - {probe_q[DATA_W-1], probe_q};
  assign diff_hi = {rd_val[DATA_W-1], rd_val} - {query_q[DATA_W-1], query_q};
  assign pick_hi = (diff_lo >= diff_hi);

  assign in_xfer  = req_i.valid && req_i.ready;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);

  // bisection sequencer, one table read per cycle
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    res_d   = res_q;
    query_d = query_q;
    probe_d = probe_q;
    rd_idx  = mid_q;
    span_n  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && req_i.req_type) begin
          query_d = req_i.data_value;
          lo_d    = '0;
          hi_d    = n_m1[IDX_W-1:0];
          mid_d   = n_m1[IDX_W:1];
          rd_idx  = n_m1[IDX_W:1];
          if (n_sat < CNT_W'(2)) begin
            res_d   = '0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (span > IDX_W'(1)) begin
          if (query_q == rd_val) begin
            res_d   = mid_q;
            state_d = ST_FINISH;
          end else begin
            if (query_q > rd_val) begin
              lo_d = mid_q;
            end else begin
              hi_d = mid_q;
            end
            span_n = hi_d - lo_d;
            mid_d  = lo_d + (span_n >> 1);
            rd_idx = mid_d;
          end
        end else begin
          probe_d = rd_val;
          rd_idx  = mid_q + IDX_W'(1);
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        res_d   = pick_hi ? (mid_q + IDX_W'(1)) : mid_q;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search payload, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
    query_q <= query_d;
    probe_q <= probe_d;
  end

  // output register, holds a result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_idx_d   = res_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
  end

  // table writes only from idle, so a search never overlaps a write
  assign req_i.ready       = (state_q == ST_IDLE);
  assign mem_req_o.wr_en   = in_xfer && !req_i.req_type;
  assign mem_req_o.wr_idx  = req_i.entry_index;
  assign mem_req_o.wr_data = req_i.data_value;
  assign mem_req_o.rd_idx  = rd_idx;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.nearest_index = out_idx_q;

  assign status_o.busy    = (state_q != ST_IDLE);
  assign status_o.probing = (state_q == ST_PROBE);

endmodule

`default_nettype wire

### rtl/nearest_value_binary_search_unit.sv
// nearest_value_binary_search_unit: top level, table memory plus search controller
// depends on nvbs_pkg, nvbs_if, nvbs_table and nvbs_ctrl
`default_nettype none

// Holds an ascending table of signed 32-bit values and answers nearest-value
// queries. A write item (req_type 0) stores data_value at entry_index and gives
// no result; slots at or above TABLE_DEPTH are dropped. A query (req_type 1)
// bisects the first entry_count slots and returns the index of the nearest
// entry, ties to the higher index, and 0 when fewer than two entries are in use.
// The table sits in a single-port-read memory with a registered read, so the
// search issues one probe per cycle: a query goes through an accept step, the
// bisection probes, a probe that issues the final neighbor read, a compare step
// and a step that loads the result register (fewer steps on an early exact
// match, and straight to the result load when fewer than two entries are in
// use). A finished result waits in the output register while the next item is
// taken; a result that finds the register still full holds the search in its
// finish state until the pending result is taken. Table contents are undefined
// until written; there is no clearing pass. entry_count must be written only
// while idle; the block itself does not enforce this.
module nearest_value_binary_search_unit
  import nvbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  nvbs_req_if.sink              req_i,
  nvbs_rsp_if.source            rsp_o
);

  mem_req_t          mem_req;
  ctrl_status_t      status;
  logic [DATA_W-1:0] rd_data;

  // search controller
  nvbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rd_data_i   (rd_data),
    .mem_req_o   (mem_req),
    .status_o    (status)
  );

  // value table
  nvbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

`ifndef ASSERT_OFF
  // no transfer in while a search runs
  a_busy_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !req_i.ready)
    else $error("input ready while search busy");

  // a query transfer starts a search
  a_query_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type) |=> status.busy)
    else $error("query transfer did not start a search");

  // probe reads stay inside the table
  a_probe_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.probing |-> (32'(mem_req.rd_idx) < TABLE_DEPTH))
    else $error("probe read beyond table depth");

  // table writes never overlap a search
  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> !status.busy)
    else $error("table write during search");
`endif

endmodule

`default_nettype wire

### verif/tb_nearest_value_binary_search_unit.sv
// testbench for nearest_value_binary_search_unit: loads tables, moves entry_count
// between phases and checks every query answer against an in-bench search
// depends on nvbs_pkg, nvbs_if and the top level from the rtl folder
`timescale 1ns / 1ps

module tb_nearest_value_binary_search_unit;
  import nvbs_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 32;
  localparam int          CLK_HALF       = 10;
  localparam int          RESET_CYCLES   = 8;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_ITEMS   = 500;
  localparam int          CALM_AFTER     = 430;
  localparam logic        OP_WRITE       = 1'b0;
  localparam logic        OP_QUERY       = 1'b1;
  localparam longint      VALUE_MIN      = -64'sd2147483648;
  localparam longint      VALUE_MAX      = 64'sd2147483647;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] data_value;
  } req_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  nvbs_req_if req_bus ();
  nvbs_rsp_if rsp_bus ();

  nearest_value_binary_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // stimulus side state
  req_item_t        pending_q[$];
  req_item_t        drive_item;
  longint           stim_table [TABLE_DEPTH];
  int               items_sent;
  int               req_gap;
  int               rsp_hold;
  bit               no_idle;
  logic             req_fired;

  // predictor state, updated at each transfer
  logic signed [DATA_W-1:0] model_table [TABLE_DEPTH];
  logic [CNT_W-1:0]         model_count;
  logic [IDX_W-1:0]         nearest_q[$];
  logic [IDX_W-1:0]         want_index;
  int                       error_count;
  int                       quiet_cycles;

  // bisection over the slots in use, nearest-of-two at the end
  function automatic logic [IDX_W-1:0] find_nearest(input logic signed [DATA_W-1:0] key);
    int unsigned used, lo, hi, mid;
    longint target, probe;
    used = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
    if (used < 2) return '0;
    target = key;
    lo = 0;
    hi = used - 1;
    mid = lo + (hi - lo) / 2;
    probe = model_table[mid];
    while (hi - lo > 1) begin
      if (target == probe) return mid[IDX_W-1:0];
      if (target > probe) lo = mid;
      else hi = mid;
      mid = lo + (hi - lo) / 2;
      probe = model_table[mid];
    end
    // ties go to the upper neighbor
    if (target - probe >= longint'(model_table[mid + 1]) - target) return IDX_W'(mid + 1);
    return mid[IDX_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_item(input logic kind, input int slot, input longint value);
    req_item_t req_item;
    req_item.req_type    = kind;
    req_item.entry_index = slot[IDX_W-1:0];
    req_item.data_value  = value[DATA_W-1:0];
    pending_q.push_back(req_item);
    if (kind == OP_WRITE) stim_table[slot] = longint'(req_item.data_value);
    items_sent++;
  endtask

  // nothing queued, nothing in flight, then let the block settle
  task automatic wait_idle();
    while (pending_q.size() != 0 || req_bus.valid || nearest_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_count(input int value);
    wait_idle();
    cfg_wdata_i <= value[CNT_W-1:0];
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // request driver: one item per transfer, random gaps between items
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_gap = 0;
    end else if (!req_bus.valid || req_fired) begin
      if (!no_idle && req_gap == 0 && $urandom_range(0, 5) == 0)
        req_gap = $urandom_range(1, 18);
      if (req_gap != 0 || pending_q.size() == 0) begin
        req_bus.valid <= 1'b0;
        if (req_gap != 0) req_gap--;
      end else begin
        drive_item = pending_q.pop_front();
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= drive_item.req_type;
        req_bus.entry_index <= drive_item.entry_index;
        req_bus.data_value  <= drive_item.data_value;
      end
    end
  end

  // response back-pressure in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      rsp_hold = 0;
    end else if (rsp_hold != 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_hold--;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_hold = $urandom_range(0, 17);
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // monitor: predict on request transfer, check on response transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_fired <= 1'b0;
      model_count = '0;
      quiet_cycles = 0;
    end else begin
      req_fired <= req_bus.valid && req_bus.ready;
      if (cfg_we_i) model_count = cfg_wdata_i;
      if (req_bus.valid && req_bus.ready) begin
        if (req_bus.req_type == OP_WRITE) model_table[req_bus.entry_index] = req_bus.data_value;
        else nearest_q.push_back(find_nearest(req_bus.data_value));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch("result with nothing expected", rsp_bus.nearest_index, -1);
        end else begin
          want_index = nearest_q.pop_front();
          if (rsp_bus.nearest_index !== want_index)
            report_mismatch("nearest_index", rsp_bus.nearest_index, want_index);
        end
      end
      // watchdog on cycles without any transfer
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus: directed cases, then random phases of table load plus queries
  initial begin
    int          count, n_used, n_pick, k, queries;
    int unsigned style, pick;
    longint      value, step_max, lo_v, hi_v;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = OP_WRITE;
    req_bus.entry_index = '0;
    req_bus.data_value  = '0;
    rsp_bus.ready       = 1'b0;
    items_sent  = 0;
    error_count = 0;
    no_idle     = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) stim_table[i] = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: always slot 0
    push_item(OP_QUERY, 0, VALUE_MIN);
    push_item(OP_QUERY, 31, VALUE_MAX);
    push_item(OP_WRITE, 0, VALUE_MIN);
    push_item(OP_WRITE, 1, VALUE_MAX);
    // single entry in use
    write_count(1);
    push_item(OP_QUERY, 0, 5);
    // two extreme entries, differences beyond 32 bits
    write_count(2);
    push_item(OP_QUERY, 0, 0);
    push_item(OP_QUERY, 0, -1);
    push_item(OP_QUERY, 0, VALUE_MIN);
    push_item(OP_QUERY, 0, VALUE_MAX);
    // three entries: exact match on the first probe and ties
    push_item(OP_WRITE, 0, -10);
    push_item(OP_WRITE, 1, 0);
    push_item(OP_WRITE, 2, 10);
    write_count(3);
    push_item(OP_QUERY, 0, 0);
    push_item(OP_QUERY, 0, -5);
    push_item(OP_QUERY, 0, 5);
    push_item(OP_QUERY, 0, -11);

    items_sent = 0;
    for (int phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      if (items_sent >= CALM_AFTER) no_idle = 1'b1;
      // pick the count, full depth and beyond first
      if (phase == 0) count = TABLE_DEPTH;
      else if (phase == 1) count = 63;
      else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       count = $urandom_range(0, 1);
          1:       count = 2;
          2:       count = $urandom_range(TABLE_DEPTH + 1, 63);
          3:       count = TABLE_DEPTH;
          default: count = $urandom_range(3, TABLE_DEPTH - 1);
        endcase
      end
      n_used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      write_count(count);

      // load the slots in use: wide ascending, dense with repeats, or unsorted
      style = $urandom_range(0, 9);
      step_max = ($urandom_range(0, 1) != 0) ? 64'd134217728 : 64'd4194304;
      if (style >= 4) value = VALUE_MIN + longint'($urandom_range(0, 32'h8000_0000));
      else value = longint'($signed($urandom));
      for (int s = 0; s < n_used; s++) begin
        if (style <= 1) value = longint'($signed($urandom));
        else if (style <= 3) value = value + $urandom_range(0, 3);
        else value = value + longint'($urandom_range(0, step_max));
        if (value > VALUE_MAX) value = VALUE_MAX;
        push_item(OP_WRITE, s, value);
      end

      // queries around table values, with a few stray writes mixed in
      n_pick = (n_used == 0) ? 1 : n_used;
      queries = $urandom_range(5, 30);
      for (int q = 0; q < queries; q++) begin
        if ($urandom_range(0, 19) == 0)
          push_item(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1), longint'($signed($urandom)));
        k = $urandom_range(0, n_pick - 1);
        pick = $urandom_range(0, 19);
        if (pick <= 5) begin
          value = stim_table[k];
        end else if (pick <= 9) begin
          value = stim_table[k] + (($urandom_range(0, 1) != 0) ? 1 : -1);
        end else if (pick <= 12 && n_used >= 2) begin
          k = $urandom_range(0, n_used - 2);
          lo_v = stim_table[k];
          hi_v = stim_table[k + 1];
          value = ((lo_v + hi_v) >>> 1) + longint'($urandom_range(0, 1));
        end else if (pick == 13) begin
          value = ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
        end else begin
          value = longint'($signed($urandom));
        end
        if (value > VALUE_MAX) value = VALUE_MAX;
        if (value < VALUE_MIN) value = VALUE_MIN;
        push_item(OP_QUERY, $urandom_range(0, TABLE_DEPTH - 1), value);
      end
    end

    // drain and let the block finish
    while (pending_q.size() != 0 || req_bus.valid || nearest_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### nearest_value_binary_search_unit.f
rtl/nvbs_pkg.sv
rtl/nvbs_if.sv
rtl/nvbs_table.sv
rtl/nvbs_ctrl.sv
rtl/nearest_value_binary_search_unit.sv
verif/tb_nearest_value_binary_search_unit.sv
